@@ rtl/kks_pkg.sv @@
package kks_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_KEY     = 2'd1;
   localparam logic [1:0] CMD_DATA    = 2'd2;

   // Register indexes on the configuration port (one 64-bit word each).
   localparam logic [1:0] REG_NONCE     = 2'd0;
   localparam logic [1:0] REG_DIRECTION = 2'd1;
   localparam logic [1:0] REG_EXPECTED  = 2'd2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Hash and generator constants.
   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_A     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_B     = 64'h94d049bb133111eb;
   localparam logic [63:0] KEY_SEED  = 64'hd6e8feb86659fd93;
   localparam logic [7:0]  POS_STEP  = 8'd131;
   localparam logic [3:0]  WORD_BYTES = 4'd8;

   // The FNV prime is 2^40 + 0x1b3, so its product is a shift plus a small multiple.
   localparam logic [8:0] FNV_PRIME_LOW   = 9'h1b3;
   localparam int         FNV_PRIME_SHIFT = 40;

   // Partial product steps of the shared 32x32 multiplier.
   localparam logic [1:0] MUL_LO_LO = 2'd0;
   localparam logic [1:0] MUL_LO_HI = 2'd1;
   localparam logic [1:0] MUL_HI_LO = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [63:0] checksum;
      logic        checksum_ok;
      logic        end_of_stream;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       restart;
      logic       key_fold;
      logic       seed;
      logic       advance;
      logic [1:0] mul_step;
      logic       mul_b;
      logic       acc_load;
      logic       acc_add;
      logic       mix_a;
      logic       mix_b;
      logic       emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] cmd;
      logic       started;
      logic       word_empty;
      logic       rsp_free;
   } dp_status_type;

   // Multiply by the FNV-1a 64 prime, modulo 2^64.
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      logic [63:0] low_part;
      low_part = x * FNV_PRIME_LOW;
      return (x << FNV_PRIME_SHIFT) + low_part;
   endfunction

endpackage

@@ rtl/kks_csr.sv @@
module kks_csr
   import kks_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [63:0]           nonce,
   output logic                  direction,
   output logic [63:0]           expected_checksum
);

   logic [63:0] nonce_ff, nonce_in;
   logic        direction_ff, direction_in;
   logic [63:0] expected_ff, expected_in;
   logic [1:0]  reg_index;
   logic        write_en;

   // Registers sit at eight-byte strides.
   assign reg_index  = csr_paddr[4:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Register write decode.
   always_comb begin
      nonce_in     = nonce_ff;
      direction_in = direction_ff;
      expected_in  = expected_ff;
      if (write_en) begin
         case (reg_index)
            REG_NONCE:     nonce_in     = csr_pwdata;
            REG_DIRECTION: direction_in = csr_pwdata[0];
            REG_EXPECTED:  expected_in  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonce_ff     <= '0;
         direction_ff <= 1'b0;
         expected_ff  <= '0;
      end else begin
         nonce_ff     <= nonce_in;
         direction_ff <= direction_in;
         expected_ff  <= expected_in;
      end
   end

   // Read data.
   always_comb begin
      case (reg_index)
         REG_NONCE:     csr_prdata = nonce_ff;
         REG_DIRECTION: csr_prdata = {63'd0, direction_ff};
         REG_EXPECTED:  csr_prdata = expected_ff;
         default:       csr_prdata = '0;
      endcase
   end

   assign nonce             = nonce_ff;
   assign direction         = direction_ff;
   assign expected_checksum = expected_ff;

endmodule

@@ rtl/kks_ctrl.sv @@
module kks_ctrl
   import kks_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISPATCH = 8'b0000_0010,
      ST_ADVANCE  = 8'b0000_0100,
      ST_MUL_A    = 8'b0000_1000,
      ST_MIX_A    = 8'b0001_0000,
      ST_MUL_B    = 8'b0010_0000,
      ST_MIX_B    = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] mul_cnt_ff, mul_cnt_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      mul_cnt_in = mul_cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.cmd)
               CMD_RESTART: begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
               CMD_KEY: begin
                  cmd.key_fold = 1'b1;
                  state_in     = ST_IDLE;
               end
               CMD_DATA: begin
                  // A fresh stream seeds the generator before its first draw.
                  if (!status.started) begin
                     cmd.seed = 1'b1;
                     state_in = ST_ADVANCE;
                  end else if (status.word_empty) begin
                     state_in = ST_ADVANCE;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            mul_cnt_in  = '0;
            state_in    = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul_step = mul_cnt_ff;
            cmd.acc_load = (mul_cnt_ff == 2'd1);
            cmd.acc_add  = mul_cnt_ff[1];
            mul_cnt_in   = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd3) begin
               state_in = ST_MIX_A;
            end
         end
         ST_MIX_A: begin
            cmd.mix_a  = 1'b1;
            mul_cnt_in = '0;
            state_in   = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_step = mul_cnt_ff;
            cmd.mul_b    = 1'b1;
            cmd.acc_load = (mul_cnt_ff == 2'd1);
            cmd.acc_add  = mul_cnt_ff[1];
            mul_cnt_in   = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd3) begin
               state_in = ST_MIX_B;
            end
         end
         ST_MIX_B: begin
            cmd.mix_b = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait here while the result register still holds an untaken response.
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mul_cnt_ff <= mul_cnt_in;
      end
   end

endmodule

@@ rtl/kks_dp.sv @@
module kks_dp
   import kks_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic [63:0]   nonce,
   input  logic          direction,
   input  logic [63:0]   expected_checksum
);

   req_type     item_ff, item_in;
   logic [63:0] key_hash_ff, key_hash_in;
   logic [63:0] gen_ff, gen_in;
   logic [63:0] ks_ff, ks_in;
   logic [3:0]  left_ff, left_in;
   logic [7:0]  pos_ff, pos_in;
   logic [63:0] csum_ff, csum_in;
   logic        started_ff, started_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mul_ff, mul_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [63:0] rsp_csum_ff, rsp_csum_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] op_a, op_b;
   logic [63:0] mix_const;
   logic [63:0] gen_step;
   logic [7:0]  out_byte;
   logic [7:0]  plain;
   logic [63:0] csum_next;
   logic        do_restart;

   // Shared 32x32 multiplier: the low 64 bits of z*C from three partial products.
   assign mix_const = cmd.mul_b ? MIX_B : MIX_A;
   assign op_a      = (cmd.mul_step == MUL_HI_LO) ? z_ff[63:32] : z_ff[31:0];
   assign op_b      = (cmd.mul_step == MUL_LO_HI) ? mix_const[63:32] : mix_const[31:0];
   assign mul_in    = op_a * op_b;

   // Keystream byte and plaintext checksum for the current data byte.
   assign gen_step  = gen_ff + GOLDEN;
   assign out_byte  = item_ff.data_byte ^ (ks_ff[7:0] + pos_ff * POS_STEP);
   assign plain     = direction ? out_byte : item_ff.data_byte;
   assign csum_next = fnv_mul(csum_ff ^ {56'd0, plain});
   assign do_restart = cmd.restart || (cmd.emit && item_ff.last);

   always_comb begin
      item_in      = item_ff;
      key_hash_in  = key_hash_ff;
      gen_in       = gen_ff;
      ks_in        = ks_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      csum_in      = csum_ff;
      started_in   = started_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_csum_in  = rsp_csum_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.latch) begin
         item_in = req_data;
      end
      if (cmd.key_fold) begin
         key_hash_in = fnv_mul(key_hash_ff ^ {56'd0, item_ff.data_byte});
      end
      if (cmd.seed) begin
         gen_in     = key_hash_ff ^ (nonce + GOLDEN);
         started_in = 1'b1;
      end
      if (cmd.advance) begin
         gen_in = gen_step;
         z_in   = gen_step ^ (gen_step >> 30);
      end
      if (cmd.acc_load) begin
         acc_in = mul_ff;
      end
      if (cmd.acc_add) begin
         acc_in = acc_ff + {mul_ff[31:0], 32'd0};
      end
      if (cmd.mix_a) begin
         z_in = acc_ff ^ (acc_ff >> 27);
      end
      if (cmd.mix_b) begin
         ks_in   = acc_ff ^ (acc_ff >> 31);
         left_in = WORD_BYTES;
      end
      if (cmd.emit) begin
         ks_in        = ks_ff >> 8;
         left_in      = left_ff - 4'd1;
         pos_in       = pos_ff + 8'd1;
         csum_in      = csum_next;
         rsp_byte_in  = out_byte;
         rsp_csum_in  = csum_next;
         rsp_last_in  = item_ff.last;
         rsp_valid_in = 1'b1;
      end
      // A restart request or the end of a stream reseeds from the current nonce.
      if (do_restart) begin
         key_hash_in = nonce ^ KEY_SEED;
         started_in  = 1'b0;
         left_in     = '0;
         pos_in      = '0;
         csum_in     = FNV_BASIS;
      end
   end

   // Stream state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hash_ff  <= KEY_SEED;
         gen_ff       <= '0;
         ks_ff        <= '0;
         left_ff      <= '0;
         pos_ff       <= '0;
         csum_ff      <= FNV_BASIS;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_hash_ff  <= key_hash_in;
         gen_ff       <= gen_in;
         ks_ff        <= ks_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         csum_ff      <= csum_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      z_ff        <= z_in;
      acc_ff      <= acc_in;
      mul_ff      <= mul_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_csum_ff <= rsp_csum_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.cmd        = item_ff.cmd;
   assign status.started    = started_ff;
   assign status.word_empty = (left_ff == 4'd0);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Match flag vs expected register: the user must keep it still while a result waits.
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.out_byte      = rsp_byte_ff;
   assign rsp_data.checksum      = rsp_csum_ff;
   assign rsp_data.checksum_ok   = rsp_last_ff && (rsp_csum_ff == expected_checksum);
   assign rsp_data.end_of_stream = rsp_last_ff;

endmodule

@@ rtl/keyed_keystream_xor_with_checksum.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_type: cmd, data_byte, last
// rsp_      out        rsp_valid / rsp_ready  rsp_type: out_byte, checksum, checksum_ok,
//                                             end_of_stream
// csr_      in         APB, pready always 1   nonce, direction, expected_checksum
//
// Restart and key requests are done in the dispatch step; a data byte from the current
// keystream word goes from dispatch straight to the output step.
// A data byte that draws a new word first runs the advance, multiply and mix steps: both
// 64-bit splitmix products run as three partial products on one shared 32x32 multiplier.
// Reset is synchronous and returns the stream to its start, keyed from a zero nonce.
// A waiting result stalls only the output step of the next data byte.
module keyed_keystream_xor_with_checksum
   import kks_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [63:0]   nonce;
   logic          direction;
   logic [63:0]   expected_checksum;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   kks_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .nonce             (nonce),
      .direction         (direction),
      .expected_checksum (expected_checksum)
   );

   kks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kks_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .nonce             (nonce),
      .direction         (direction),
      .expected_checksum (expected_checksum)
   );

endmodule

@@ rtl/kks_checker.sv @@
module kks_checker
   import kks_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // The match flag only appears on the final byte of a stream.
   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.checksum_ok |-> rsp_data.end_of_stream)
      else $error("checksum match flagged before end of stream");

   // No request is accepted in the cycle after another is accepted.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

endmodule

bind keyed_keystream_xor_with_checksum kks_checker u_checker (.*);
